>>> rtl/core/hnud_pkg.sv
// Shared types and constants of the HEVC NAL unit dropper.
`timescale 1ns / 1ps

package hnud_pkg;

    localparam int NUM_TYPES          = 64;
    localparam int TYPE_BITS          = 6;
    localparam int COUNT_BITS_DEFAULT = 32;
    localparam int MAX_RESULTS        = 5;
    localparam int SLOT_BITS          = 3;

    localparam logic [2:0] MODE_RESET = 3'd1;

    localparam logic [1:0] FUNC_BYTE  = 2'd0;
    localparam logic [1:0] FUNC_FLUSH = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] KIND_PASS      = 2'd0;
    localparam logic [1:0] KIND_FORBIDDEN = 2'd1;
    localparam logic [1:0] KIND_EARLY     = 2'd2;
    localparam logic [1:0] KIND_COUNT     = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic       loss_flag;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [31:0] type_read_count;
        logic [31:0] type_written_count;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0]             n;
        logic [MAX_RESULTS-1:0][1:0]      kinds;
        logic [MAX_RESULTS-1:0][7:0]      bytes;
    } burst_t;

    typedef struct packed {
        logic                 inc;
        logic                 inc_written;
        logic [TYPE_BITS-1:0] idx;
    } cnt_op_t;

endpackage

>>> rtl/core/hnud_counters.sv
// Per-type unit counters held in one memory with a registered read-modify-write.
`timescale 1ns / 1ps

module hnud_counters #(
    parameter int COUNT_BITS = hnud_pkg::COUNT_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_valid,
    input  hnud_pkg::cnt_op_t op,
    output logic [31:0]      read_count,
    output logic [31:0]      written_count
);
    import hnud_pkg::*;

    localparam int ROW_BITS = 2 * COUNT_BITS;
    localparam int EXT_BITS = (COUNT_BITS > 32) ? COUNT_BITS : 32;

    logic [ROW_BITS-1:0]   mem [NUM_TYPES];
    logic [NUM_TYPES-1:0]  valid_reg;
    logic [ROW_BITS-1:0]   rd_data_reg;
    logic [ROW_BITS-1:0]   fwd_data_reg;
    logic                  rd_hit_reg;
    logic                  fwd_reg;
    logic                  inc_reg;
    logic                  inc_written_reg;
    logic [TYPE_BITS-1:0]  wr_idx_reg;
    logic [ROW_BITS-1:0]   row;
    logic [ROW_BITS-1:0]   wr_row;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [COUNT_BITS-1:0] wr_cnt;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [31:0] sat32(input logic [COUNT_BITS-1:0] v);
        logic [EXT_BITS-1:0] w;
        w = EXT_BITS'(v);
        return (w > EXT_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    always_comb
    begin
        if (fwd_reg)
        begin
            row = fwd_data_reg;
        end
        else if (rd_hit_reg)
        begin
            row = rd_data_reg;
        end
        else
        begin
            row = '0;
        end
        rd_cnt = row[COUNT_BITS-1:0];
        wr_cnt = row[ROW_BITS-1:COUNT_BITS];
        wr_row = {(inc_written_reg ? sat_inc(wr_cnt) : wr_cnt), sat_inc(rd_cnt)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            inc_reg         <= 1'b0;
            inc_written_reg <= 1'b0;
            rd_hit_reg      <= 1'b0;
            fwd_reg         <= 1'b0;
        end
        else
        begin
            if (inc_reg)
            begin
                valid_reg[wr_idx_reg] <= 1'b1;
            end
            inc_reg         <= op_valid && op.inc;
            inc_written_reg <= op_valid && op.inc_written;
            if (op_valid)
            begin
                rd_hit_reg <= valid_reg[op.idx];
                fwd_reg    <= inc_reg && (wr_idx_reg == op.idx);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (inc_reg)
        begin
            mem[wr_idx_reg] <= wr_row;
        end
        if (op_valid)
        begin
            rd_data_reg  <= mem[op.idx];
            fwd_data_reg <= wr_row;
            wr_idx_reg   <= op.idx;
        end
    end

    assign read_count    = sat32(rd_cnt);
    assign written_count = sat32(wr_cnt);

    // Two unit headers can never arrive on consecutive words.
    assert property (@(posedge clk) disable iff (!rst_n) inc_reg |=> !inc_reg)
        else $error("counter increments on consecutive cycles");

endmodule

>>> rtl/core/hnud_parser.sv
// Start code search, unit header decode and result burst forming.
`timescale 1ns / 1ps

module hnud_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  hnud_pkg::in_word_t item,
    input  logic [2:0]         apply_mode,
    output hnud_pkg::burst_t   burst,
    output hnud_pkg::cnt_op_t  op
);
    import hnud_pkg::*;

    typedef enum logic [1:0] {PH_HUNT, PH_HEAD, PH_BODY} phase_t;

    localparam logic [TYPE_BITS-1:0] TYPE_VPS    = 6'd32;
    localparam logic [TYPE_BITS-1:0] TYPE_SPS    = 6'd33;
    localparam logic [TYPE_BITS-1:0] TYPE_PPS    = 6'd34;
    localparam logic [TYPE_BITS-1:0] TYPE_IDR_WR = 6'd19;
    localparam logic [TYPE_BITS-1:0] TYPE_IDR_NL = 6'd20;
    localparam logic [TYPE_BITS-1:0] TYPE_CRA    = 6'd21;

    phase_t     phase_reg, phase_next;
    logic [1:0] zero_run_reg, zero_run_next;
    logic       keep_reg, keep_next;
    logic [1:0] rel_kind;
    logic       rel_emit;
    logic [TYPE_BITS-1:0] unit_type;
    logic [7:0] b;

    function automatic logic exposed(input logic [TYPE_BITS-1:0] t, input logic [2:0] mode);
        logic ps;
        logic idr;
        logic res;
        ps  = (t == TYPE_VPS) || (t == TYPE_SPS) || (t == TYPE_PPS);
        idr = (t == TYPE_IDR_WR) || (t == TYPE_IDR_NL);
        unique case (mode)
            3'd0:    res = 1'b0;
            3'd1:    res = !ps;
            3'd2:    res = !(ps || idr);
            3'd3:    res = !(ps || idr || (t == TYPE_CRA));
            default: res = 1'b1;
        endcase
        return res;
    endfunction

    always_comb
    begin
        b             = item.data_byte;
        unit_type     = b[6:1];
        burst         = '0;
        op            = '0;
        phase_next    = phase_reg;
        zero_run_next = zero_run_reg;
        keep_next     = keep_reg;
        rel_kind      = (phase_reg == PH_BODY) ? KIND_PASS : KIND_EARLY;
        rel_emit      = (phase_reg != PH_BODY) || keep_reg;

        unique case (item.func)
            FUNC_BYTE:
            begin
                if (phase_reg == PH_HEAD)
                begin
                    phase_next    = PH_BODY;
                    zero_run_next = 2'd0;
                    if (b[7])
                    begin
                        keep_next       = 1'b0;
                        burst.n         = 3'd1;
                        burst.kinds[0]  = KIND_FORBIDDEN;
                    end
                    else
                    begin
                        keep_next      = !(exposed(unit_type, apply_mode) && item.loss_flag);
                        op.inc         = 1'b1;
                        op.inc_written = keep_next;
                        op.idx         = unit_type;
                        if (keep_next)
                        begin
                            burst.n        = 3'd5;
                            burst.kinds    = '0;
                            burst.bytes[3] = 8'h01;
                            burst.bytes[4] = b;
                        end
                    end
                end
                else if (b == 8'h00)
                begin
                    if (zero_run_reg != 2'd3)
                    begin
                        zero_run_next = zero_run_reg + 2'd1;
                    end
                    else if (rel_emit)
                    begin
                        burst.n        = 3'd1;
                        burst.kinds[0] = rel_kind;
                    end
                end
                else if ((b == 8'h01) && (zero_run_reg == 2'd3))
                begin
                    phase_next    = PH_HEAD;
                    zero_run_next = 2'd0;
                end
                else
                begin
                    zero_run_next = 2'd0;
                    if (rel_emit)
                    begin
                        burst.n = {1'b0, zero_run_reg} + 3'd1;
                        for (int i = 0; i < MAX_RESULTS; i++)
                        begin
                            if (SLOT_BITS'(i) <= {1'b0, zero_run_reg})
                            begin
                                burst.kinds[i] = rel_kind;
                            end
                            if ((SLOT_BITS'(i) == {1'b0, zero_run_reg}) &&
                                (rel_kind == KIND_PASS))
                            begin
                                burst.bytes[i] = b;
                            end
                        end
                    end
                end
            end
            FUNC_FLUSH:
            begin
                if ((phase_reg != PH_HEAD) && rel_emit)
                begin
                    burst.n = {1'b0, zero_run_reg};
                    for (int i = 0; i < MAX_RESULTS; i++)
                    begin
                        if (SLOT_BITS'(i) < {1'b0, zero_run_reg})
                        begin
                            burst.kinds[i] = rel_kind;
                        end
                    end
                end
                phase_next    = PH_HUNT;
                zero_run_next = 2'd0;
                keep_next     = 1'b0;
            end
            FUNC_READ:
            begin
                burst.n        = 3'd1;
                burst.kinds[0] = KIND_COUNT;
                op.idx         = b[TYPE_BITS-1:0];
            end
            default:
            begin
                burst.n = 3'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            zero_run_reg <= 2'd0;
            keep_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            zero_run_reg <= zero_run_next;
            keep_reg     <= keep_next;
        end
    end

endmodule

>>> rtl/core/hevc_nal_unit_dropper.sv
// Top level of the HEVC Annex B NAL unit dropper.
`timescale 1ns / 1ps

// An input word is taken in every cycle while the previous word left at most one result word
// and the output is not stalled; a word that leaves more holds the input until its burst is
// handed out, so a kept unit header (start code plus header) leaves five result words and
// an early byte after three held zeros leaves four. The rate is set by the single result
// serializer, which unless the output stalls hands out one word per cycle from a burst
// register behind the start code parser. Per-type counters live in a 64-row memory with a
// read-modify-write and forwarding; reset clears row valid bits, so no clearing pass is needed.
module hevc_nal_unit_dropper #(
    parameter int COUNT_BITS = hnud_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  hnud_pkg::in_word_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output hnud_pkg::out_word_t result,
    input  logic                cfg_write_en,
    input  logic [2:0]          cfg_write_data
);
    import hnud_pkg::*;

    logic [2:0] mode_reg;
    logic       accept;
    burst_t     burst;
    cnt_op_t    op;
    logic [31:0] read_count;
    logic [31:0] written_count;

    logic                 b_valid_reg;
    burst_t               b_burst_reg;
    logic [SLOT_BITS-1:0] b_idx_reg;
    logic                 b_last;
    logic                 b_move;
    logic                 b_done;
    logic                 c_free;
    logic                 c_valid_reg;
    out_word_t            c_word_reg;
    out_word_t            c_word_next;

    hnud_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (item),
        .apply_mode (mode_reg),
        .burst      (burst),
        .op         (op)
    );

    hnud_counters #(
        .COUNT_BITS (COUNT_BITS)
    ) u_counters (
        .clk           (clk),
        .rst_n         (rst_n),
        .op_valid      (accept),
        .op            (op),
        .read_count    (read_count),
        .written_count (written_count)
    );

    assign b_last     = (b_idx_reg == (b_burst_reg.n - 3'd1));
    assign c_free     = !c_valid_reg || !result_stall;
    assign b_move     = b_valid_reg && c_free;
    assign b_done     = b_move && b_last;
    assign item_stall = b_valid_reg && !b_done;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        c_word_next          = '0;
        c_word_next.kind     = b_burst_reg.kinds[b_idx_reg];
        c_word_next.out_byte = b_burst_reg.bytes[b_idx_reg];
        c_word_next.last     = b_last;
        if (c_word_next.kind == KIND_COUNT)
        begin
            c_word_next.type_read_count    = read_count;
            c_word_next.type_written_count = written_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RESET;
            b_valid_reg <= 1'b0;
            b_idx_reg   <= '0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                mode_reg <= cfg_write_data;
            end
            if (accept && (burst.n != 3'd0))
            begin
                b_valid_reg <= 1'b1;
                b_idx_reg   <= '0;
            end
            else if (b_done)
            begin
                b_valid_reg <= 1'b0;
            end
            else if (b_move)
            begin
                b_idx_reg <= b_idx_reg + 3'd1;
            end
            if (b_move)
            begin
                c_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                c_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (burst.n != 3'd0))
        begin
            b_burst_reg <= burst;
        end
        if (b_move)
        begin
            c_word_reg <= c_word_next;
        end
    end

    assign result_valid = c_valid_reg;
    assign result       = c_word_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (b_idx_reg < b_burst_reg.n))
        else $error("burst slot index beyond burst length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && (c_word_reg.kind != KIND_PASS)) |-> (c_word_reg.out_byte == 8'h00))
        else $error("byte carried on a word that is not a passed byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && (c_word_reg.kind != KIND_COUNT)) |->
        ((c_word_reg.type_read_count == 32'd0) && (c_word_reg.type_written_count == 32'd0)))
        else $error("counts carried on a word that is not a readout");

endmodule
